// ----- sv/tpp_pkg.sv -----
// ----------------------------------------------------------------------------
// Tenant packet policer package
// Shared constants, verdict codes and the structs passed between the header
// check, the tenant table and the top level.
// ----------------------------------------------------------------------------
package tpp_pkg;

    // Table size default for the top-level parameter.
    localparam int TABLE_ENTRIES_DEF = 64;

    // Fixed header sizes in bytes.
    localparam int ETH_HDR_BYTES        = 14;
    localparam int IPV4_HDR_BYTES       = 20;
    localparam int UDP_HDR_BYTES        = 8;
    localparam int COMPUTE_HEADER_BYTES = 16;
    localparam int IHL_BYTES_PER_WORD   = 4;

    // Field widths.
    localparam int LEN_W      = 17;
    localparam int TOKEN_W    = 31;
    localparam int TENANT_W   = 32;
    localparam int SEC_W      = 32;
    localparam int SLOT_OUT_W = 6;
    localparam int DROP_W     = 32;

    localparam logic [15:0] ETHER_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;

    // Smallest legal frame, and the part of the required length that does not
    // depend on the packet.
    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES =
        LEN_W'(ETH_HDR_BYTES + IPV4_HDR_BYTES + UDP_HDR_BYTES + COMPUTE_HEADER_BYTES);
    localparam logic [LEN_W-1:0] FIXED_BYTES =
        LEN_W'(ETH_HDR_BYTES + UDP_HDR_BYTES + COMPUTE_HEADER_BYTES);

    localparam logic [TOKEN_W-1:0] BUCKET_SIZE_RESET = TOKEN_W'(1000);

    typedef enum logic [2:0] {
        VERDICT_PASS     = 3'd0,
        VERDICT_CKSUM    = 3'd1,
        VERDICT_SHORT    = 3'd2,
        VERDICT_NOT_IPV4 = 3'd3,
        VERDICT_NOT_UDP  = 3'd4,
        VERDICT_TRUNC    = 3'd5,
        VERDICT_FULL     = 3'd6,
        VERDICT_RATE     = 3'd7
    } t_verdict;

    // Outcome of the header checks.
    typedef struct packed {
        logic     pass;
        t_verdict verdict;
    } t_chk;

    // One result as computed by the tenant table.
    typedef struct packed {
        t_verdict               verdict;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [TOKEN_W-1:0]     tokens;
        logic [DROP_W-1:0]      drop_count;
    } t_tbl_res;

endpackage

// ----- sv/tpp_check.sv -----
// ----------------------------------------------------------------------------
// Tenant packet policer header check
// Runs the ordered header checks on one registered request and reports the
// first failing check, or a pass.
// ----------------------------------------------------------------------------
module tpp_check (
    input  logic                       i_checksum_bad,
    input  logic [15:0]                i_frame_length,
    input  logic [15:0]                i_ether_type,
    input  logic [7:0]                 i_ip_protocol,
    input  logic [3:0]                 i_ip_header_words,
    input  logic [15:0]                i_payload_length,
    output tpp_pkg::t_chk              o_chk
);

    logic [tpp_pkg::LEN_W-1:0] frame_len;
    logic [tpp_pkg::LEN_W-1:0] need_len;

    // Required length counts the IHL-sized IP header and the payload; 17 bits
    // hold the largest sum without overflow.
    assign frame_len = tpp_pkg::LEN_W'(i_frame_length);
    assign need_len  = tpp_pkg::FIXED_BYTES
                     + tpp_pkg::LEN_W'(i_ip_header_words)
                       * tpp_pkg::LEN_W'(tpp_pkg::IHL_BYTES_PER_WORD)
                     + tpp_pkg::LEN_W'(i_payload_length);

    // The checks apply in a fixed order; the first failure decides.
    always_comb begin
        o_chk.pass    = 1'b0;
        o_chk.verdict = tpp_pkg::VERDICT_PASS;
        priority if (i_checksum_bad) begin
            o_chk.verdict = tpp_pkg::VERDICT_CKSUM;
        end else if (frame_len < tpp_pkg::MIN_FRAME_BYTES) begin
            o_chk.verdict = tpp_pkg::VERDICT_SHORT;
        end else if (i_ether_type != tpp_pkg::ETHER_TYPE_IPV4) begin
            o_chk.verdict = tpp_pkg::VERDICT_NOT_IPV4;
        end else if (i_ip_protocol != tpp_pkg::IP_PROTO_UDP) begin
            o_chk.verdict = tpp_pkg::VERDICT_NOT_UDP;
        end else if (frame_len < need_len) begin
            o_chk.verdict = tpp_pkg::VERDICT_TRUNC;
        end else begin
            o_chk.pass = 1'b1;
        end
    end

endmodule

// ----- sv/tpp_table.sv -----
// ----------------------------------------------------------------------------
// Tenant packet policer tenant table
// Holds one token bucket per slot, matches the tenant against all slots at
// once, allocates the lowest free slot and keeps the saturating drop count.
// ----------------------------------------------------------------------------
module tpp_table #(
    parameter int TABLE_ENTRIES = tpp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_item_valid,
    input  tpp_pkg::t_chk                   i_chk,
    input  logic [tpp_pkg::TENANT_W-1:0]    i_tenant_id,
    input  logic [tpp_pkg::SEC_W-1:0]       i_now_seconds,
    input  logic [tpp_pkg::TOKEN_W-1:0]     i_bucket_size,
    output tpp_pkg::t_tbl_res               o_res
);

    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Slot lanes.
    logic [TABLE_ENTRIES-1:0]        r_valid;
    logic [tpp_pkg::TENANT_W-1:0]    r_tenant [TABLE_ENTRIES];
    logic [tpp_pkg::SEC_W-1:0]       r_last   [TABLE_ENTRIES];
    logic [tpp_pkg::TOKEN_W-1:0]     r_tokens [TABLE_ENTRIES];
    logic [tpp_pkg::DROP_W-1:0]      r_drop_count;
    logic [tpp_pkg::DROP_W-1:0]      n_drop_count;

    logic [TABLE_ENTRIES-1:0]        hit_vec;
    logic [TABLE_ENTRIES-1:0]        free_vec;
    logic [TABLE_ENTRIES-1:0]        hit_oh;
    logic [TABLE_ENTRIES-1:0]        free_oh;
    logic [TABLE_ENTRIES-1:0]        sel_oh;
    logic                            any_hit;
    logic                            any_free;
    logic                            slot_found;
    logic [SLOT_W-1:0]               sel_idx;
    logic [tpp_pkg::SEC_W-1:0]       sel_last;
    logic [tpp_pkg::TOKEN_W-1:0]     sel_tokens;
    logic                            refill;
    logic [tpp_pkg::TOKEN_W-1:0]     eff_tokens;
    logic                            tokens_zero;
    logic [tpp_pkg::TOKEN_W-1:0]     new_tokens;
    logic                            wr_en;
    logic                            drop_inc;

    // Parallel tenant compare across all slots.
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_tenant[i] == i_tenant_id);
        end
    end

    assign free_vec = ~r_valid;

    // Isolate the lowest set bit: lowest matching slot, lowest free slot.
    assign hit_oh   = hit_vec & (~hit_vec + TABLE_ENTRIES'(1));
    assign free_oh  = free_vec & (~free_vec + TABLE_ENTRIES'(1));
    assign any_hit  = |hit_vec;
    assign any_free = |free_vec;
    assign sel_oh   = any_hit ? hit_oh : free_oh;
    assign slot_found = any_hit || any_free;

    // One-hot selection of the chosen lane's index and bucket.
    always_comb begin
        sel_idx    = '0;
        sel_last   = '0;
        sel_tokens = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (sel_oh[i]) begin
                sel_idx    = sel_idx | SLOT_W'(i);
                sel_last   = sel_last | r_last[i];
                sel_tokens = sel_tokens | r_tokens[i];
            end
        end
    end

    // A new slot or a changed second starts from a full bucket.
    assign refill      = !any_hit || (i_now_seconds != sel_last);
    assign eff_tokens  = refill ? i_bucket_size : sel_tokens;
    assign tokens_zero = (eff_tokens == '0);
    assign new_tokens  = tokens_zero ? '0 : eff_tokens - tpp_pkg::TOKEN_W'(1);

    assign wr_en    = i_item_valid && i_chk.pass && slot_found;
    assign drop_inc = i_item_valid && i_chk.pass && !slot_found;

    // Drop count saturates at all ones.
    assign n_drop_count = (drop_inc && (r_drop_count != '1))
                        ? r_drop_count + tpp_pkg::DROP_W'(1) : r_drop_count;

    // Result for the request in flight.
    always_comb begin
        o_res.verdict    = tpp_pkg::VERDICT_PASS;
        o_res.slot       = '0;
        o_res.tokens     = '0;
        o_res.drop_count = n_drop_count;
        priority if (!i_chk.pass) begin
            o_res.verdict = i_chk.verdict;
        end else if (!slot_found) begin
            o_res.verdict = tpp_pkg::VERDICT_FULL;
        end else if (tokens_zero) begin
            o_res.verdict = tpp_pkg::VERDICT_RATE;
            o_res.slot    = tpp_pkg::SLOT_OUT_W'(sel_idx);
        end else begin
            o_res.verdict = tpp_pkg::VERDICT_PASS;
            o_res.slot    = tpp_pkg::SLOT_OUT_W'(sel_idx);
            o_res.tokens  = new_tokens;
        end
    end

    // Valid bits and drop counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_drop_count <= '0;
        end else begin
            r_drop_count <= n_drop_count;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (wr_en && sel_oh[i]) begin
                    r_valid[i] <= 1'b1;
                end
            end
        end
    end

    // Slot contents; a write on a hit rewrites the same tenant.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (wr_en && sel_oh[i]) begin
                r_tenant[i] <= i_tenant_id;
                r_last[i]   <= i_now_seconds;
                r_tokens[i] <= new_tokens;
            end
        end
    end

endmodule

// ----- sv/tenant_packet_policer.sv -----
// ----------------------------------------------------------------------------
// Tenant packet policer
// A request passes the input register, then the result register, which drives
// its result strobe. Throughput: one request per cycle; busy is never raised.
// The tenant compare over all slots and the bucket update finish in the cycle
// after the input register, so the next request always sees updated state.
// Reset clears slot valid bits and the drop count and sets bucket_size to 1000.
// ----------------------------------------------------------------------------
module tenant_packet_policer #(
    parameter int TABLE_ENTRIES = tpp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_checksum_bad,
    input  logic [15:0]                      i_frame_length,
    input  logic [15:0]                      i_ether_type,
    input  logic [7:0]                       i_ip_protocol,
    input  logic [3:0]                       i_ip_header_words,
    input  logic [15:0]                      i_payload_length,
    input  logic [tpp_pkg::TENANT_W-1:0]     i_tenant_id,
    input  logic [tpp_pkg::SEC_W-1:0]        i_now_seconds,
    input  logic                             i_cfg_we,
    input  logic [tpp_pkg::TOKEN_W-1:0]      i_cfg_wdata,
    output logic                             o_result_valid,
    output logic [2:0]                       o_verdict,
    output logic [tpp_pkg::SLOT_OUT_W-1:0]   o_tenant_slot,
    output logic [tpp_pkg::TOKEN_W-1:0]      o_tokens_left,
    output logic [tpp_pkg::DROP_W-1:0]       o_alloc_drop_count
);

    logic                            r_in_valid;
    logic                            r_checksum_bad;
    logic [15:0]                     r_frame_length;
    logic [15:0]                     r_ether_type;
    logic [7:0]                      r_ip_protocol;
    logic [3:0]                      r_ip_header_words;
    logic [15:0]                     r_payload_length;
    logic [tpp_pkg::TENANT_W-1:0]    r_tenant_id;
    logic [tpp_pkg::SEC_W-1:0]       r_now_seconds;
    logic [tpp_pkg::TOKEN_W-1:0]     r_bucket_size;
    logic                            r_res_valid;
    tpp_pkg::t_tbl_res               r_res;
    tpp_pkg::t_chk                   chk;
    tpp_pkg::t_tbl_res               tbl_res;
    logic                            accept;

    // Every request is taken as it arrives.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Bucket size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_size <= tpp_pkg::BUCKET_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_bucket_size <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_checksum_bad    <= i_checksum_bad;
            r_frame_length    <= i_frame_length;
            r_ether_type      <= i_ether_type;
            r_ip_protocol     <= i_ip_protocol;
            r_ip_header_words <= i_ip_header_words;
            r_payload_length  <= i_payload_length;
            r_tenant_id       <= i_tenant_id;
            r_now_seconds     <= i_now_seconds;
        end
    end

    // Header checks on the registered request.
    tpp_check u_check (
        .i_checksum_bad    (r_checksum_bad),
        .i_frame_length    (r_frame_length),
        .i_ether_type      (r_ether_type),
        .i_ip_protocol     (r_ip_protocol),
        .i_ip_header_words (r_ip_header_words),
        .i_payload_length  (r_payload_length),
        .o_chk             (chk)
    );

    // Tenant lookup, allocation and bucket update.
    tpp_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (r_in_valid),
        .i_chk         (chk),
        .i_tenant_id   (r_tenant_id),
        .i_now_seconds (r_now_seconds),
        .i_bucket_size (r_bucket_size),
        .o_res         (tbl_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_res <= tbl_res;
        end
    end

    assign o_result_valid     = r_res_valid;
    assign o_verdict          = r_res.verdict;
    assign o_tenant_slot      = r_res.slot;
    assign o_tokens_left      = r_res.tokens;
    assign o_alloc_drop_count = r_res.drop_count;

endmodule

// ----- sv/tpp_sva.sv -----
// ----------------------------------------------------------------------------
// Tenant packet policer port checker
// Checks request-to-result timing and the consistency of result fields as
// seen on the top-level ports.
// ----------------------------------------------------------------------------
module tpp_sva (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             o_result_valid,
    input  logic [2:0]                       o_verdict,
    input  logic [tpp_pkg::SLOT_OUT_W-1:0]   o_tenant_slot,
    input  logic [tpp_pkg::TOKEN_W-1:0]      o_tokens_left,
    input  logic [tpp_pkg::DROP_W-1:0]       o_alloc_drop_count
);

    // Exactly one result after each accepted request, and no result otherwise.
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid == ($past(start && !busy && i_rst_n, 2) && $past(i_rst_n)))
        else $error("result strobe does not follow an accepted request");

    // Header failures and a full table carry no slot and no tokens.
    a_reject_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_verdict != tpp_pkg::VERDICT_PASS)
            && (o_verdict != tpp_pkg::VERDICT_RATE)
        |-> (o_tenant_slot == '0) && (o_tokens_left == '0))
        else $error("rejected request reports a slot or tokens");

    // A rate-limited request leaves an empty bucket.
    a_rate_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_verdict == tpp_pkg::VERDICT_RATE)
        |-> (o_tokens_left == '0))
        else $error("rate-limited request reports tokens left");

    // A table-full drop is always counted.
    a_full_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_verdict == tpp_pkg::VERDICT_FULL)
        |-> (o_alloc_drop_count != '0))
        else $error("table-full drop not counted");

    // The drop count never goes down between back-to-back results.
    a_drop_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && $past(o_result_valid)
        |-> (o_alloc_drop_count >= $past(o_alloc_drop_count)))
        else $error("drop count decreased");

endmodule

bind tenant_packet_policer tpp_sva u_tpp_sva (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_result_valid     (o_result_valid),
    .o_verdict          (o_verdict),
    .o_tenant_slot      (o_tenant_slot),
    .o_tokens_left      (o_tokens_left),
    .o_alloc_drop_count (o_alloc_drop_count)
);
